// ===== rtl/lgs_pkg.sv =====
// lgs_pkg: shared types and constants for the life generation stencil unit
// no dependencies; imported by every module of the block except lgs_row_buffer

package lgs_pkg;

   // item kinds carried on the request tuser bit
   localparam logic CMD_CELL = 1'b0;
   localparam logic CMD_PAD  = 1'b1;

   // csr register indexes
   localparam logic CFG_BOARD_WIDTH  = 1'b0;
   localparam logic CFG_BOARD_HEIGHT = 1'b1;

   localparam int unsigned CSR_WIDTH = 8;

   localparam logic [CSR_WIDTH-1:0] MIN_SIDE     = 8'd3;
   localparam logic [CSR_WIDTH-1:0] WIDTH_RESET  = 8'd100;
   localparam logic [CSR_WIDTH-1:0] HEIGHT_RESET = 8'd80;

   // B3/S23 rule counts
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] KEEP_COUNT  = 4'd2;

   // one window snapshot handed from the front end to the rule stage
   typedef struct packed {
      logic [8:0] window;
      logic       border;
      logic       last;
   } stage_type;

endpackage

// ===== rtl/lgs_row_buffer.sv =====
// lgs_row_buffer: two row delay lines sharing one column address
// bit 0 holds the row just above the input, bit 1 the row two above
// depends on nothing outside this file

module lgs_row_buffer #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                         clock,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [1:0]                   wr_data,
   output logic [1:0]                   rd_data
);

   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] mem_rd_ff;
   logic [1:0] bypass_data_ff;
   logic       bypass_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_rd_ff <= mem[rd_addr];
   end

   // same-address read and write in the same cycle returns the new data
   always_ff @(posedge clock) begin
      bypass_ff      <= wr_en && (wr_addr == rd_addr);
      bypass_data_ff <= wr_data;
   end

   assign rd_data = bypass_ff ? bypass_data_ff : mem_rd_ff;

endmodule

// ===== rtl/lgs_window_ctrl.sv =====
// lgs_window_ctrl: csr registers, raster position counters and the 3x3 window
// drives the row buffer port and hands a window snapshot to the rule stage; uses lgs_pkg

module lgs_window_ctrl #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [lgs_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  logic                         req_valid,
   input  logic                         req_cmd,
   input  logic                         req_cell,
   output logic                         req_ready,
   input  logic                         out_ready,
   output logic                         s1_valid,
   output lgs_pkg::stage_type           s1_stage,
   output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic                         wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   output logic [1:0]                   wr_data,
   input  logic [1:0]                   rd_data
);

   import lgs_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT + 2);
   localparam int OW   = $clog2(MAX_HEIGHT);
   localparam int CMPW = (CW + 1 > CSR_WIDTH) ? CW + 1 : CSR_WIDTH;
   localparam int CMPH = (RW > CSR_WIDTH) ? RW : CSR_WIDTH;
   localparam int WMAX = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
   localparam int HMAX = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

   logic [CSR_WIDTH-1:0] width_ff, width_in;
   logic [CSR_WIDTH-1:0] height_ff, height_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        ocol_ff, ocol_in;
   logic [OW-1:0]        orow_ff, orow_in;
   logic [8:0]           window_ff, window_in;
   logic                 s1_valid_ff, s1_valid_in;
   stage_type            s1_ff, s1_in;

   logic                 accept;
   logic                 bit_in;
   logic [8:0]           window_shift;
   logic                 emit;
   logic                 col_wrap;
   logic                 ocol_first, ocol_end, orow_first, orow_end;
   logic                 border, last;
   logic [CSR_WIDTH-1:0] clamp_w, clamp_h;

   assign req_ready = !s1_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   // a pad counts as a dead cell
   assign bit_in       = (req_cmd == CMD_PAD) ? 1'b0 : req_cell;
   assign window_shift = {window_ff[5:0], bit_in, rd_data[0], rd_data[1]};

   assign emit     = (row_ff >= RW'(2)) || ((row_ff == RW'(1)) && (col_ff != '0));
   assign col_wrap = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(width_ff);

   assign ocol_first = (ocol_ff == '0);
   assign ocol_end   = (CMPW'(ocol_ff) == CMPW'(width_ff - 8'd1));
   assign orow_first = (orow_ff == '0);
   assign orow_end   = (CMPH'(orow_ff) == CMPH'(height_ff - 8'd1));
   assign border     = ocol_first || ocol_end || orow_first || orow_end;
   assign last       = ocol_end && orow_end;

   always_comb begin
      if (csr_wdata < MIN_SIDE) begin
         clamp_w = MIN_SIDE;
         clamp_h = MIN_SIDE;
      end else begin
         clamp_w = (csr_wdata > CSR_WIDTH'(WMAX)) ? CSR_WIDTH'(WMAX) : csr_wdata;
         clamp_h = (csr_wdata > CSR_WIDTH'(HMAX)) ? CSR_WIDTH'(HMAX) : csr_wdata;
      end
   end

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      window_in   = window_ff;
      s1_valid_in = s1_valid_ff && !out_ready;
      s1_in       = s1_ff;
      if (csr_we) begin
         case (csr_index)
            CFG_BOARD_WIDTH:  width_in  = clamp_w;
            CFG_BOARD_HEIGHT: height_in = clamp_h;
            default:          width_in  = width_ff;
         endcase
         // any csr write restarts the frame
         col_in    = '0;
         row_in    = '0;
         ocol_in   = '0;
         orow_in   = '0;
         window_in = '0;
      end else if (accept) begin
         window_in = window_shift;
         if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
         if (emit) begin
            s1_valid_in  = 1'b1;
            s1_in.window = window_shift;
            s1_in.border = border;
            s1_in.last   = last;
            if (last) begin
               col_in    = '0;
               row_in    = '0;
               ocol_in   = '0;
               orow_in   = '0;
               window_in = '0;
            end else if (ocol_end) begin
               ocol_in = '0;
               orow_in = orow_ff + OW'(1);
            end else begin
               ocol_in = ocol_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         window_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         window_ff   <= window_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // read ahead at the column of the next item
   assign rd_addr = col_in;
   assign wr_en   = accept && !csr_we;
   assign wr_addr = col_ff;
   assign wr_data = {rd_data[0], bit_in};

   assign s1_valid = s1_valid_ff;
   assign s1_stage = s1_ff;

`ifndef NO_ASSERTIONS
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      CMPW'(col_ff) < CMPW'(width_ff))
      else $error("input column beyond board width");

   a_orow_in_frame: assert property (@(posedge clock) disable iff (reset)
      CMPH'(orow_ff) < CMPH'(height_ff))
      else $error("output row beyond board height");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |-> !req_ready)
      else $error("input taken while stage one is stalled");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && last && !csr_we) |=>
         (col_ff == '0 && row_ff == '0 && ocol_ff == '0 && orow_ff == '0))
      else $error("position not restarted after last cell of frame");
`endif

endmodule

// ===== rtl/lgs_rule_stage.sv =====
// lgs_rule_stage: B3/S23 rule on a window snapshot and the result register
// border cells keep their centre value; uses lgs_pkg

module lgs_rule_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  lgs_pkg::stage_type s1_stage,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               next_alive,
   output logic               frame_last
);

   import lgs_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       next_ff, last_ff;
   logic [3:0] neighbours;
   logic       centre;
   logic       next_value;

   // centre cell sits at bit 4, the other eight are neighbours
   assign centre     = s1_stage.window[4];
   assign neighbours = 4'($countones({s1_stage.window[8:5], s1_stage.window[3:0]}));

   always_comb begin
      if (s1_stage.border) begin
         next_value = centre;
      end else if (centre) begin
         next_value = (neighbours == KEEP_COUNT) || (neighbours == BIRTH_COUNT);
      end else begin
         next_value = (neighbours == BIRTH_COUNT);
      end
   end

   assign out_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_ready ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid) begin
         next_ff <= next_value;
         last_ff <= s1_stage.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign next_alive = next_ff;
   assign frame_last = last_ff;

endmodule

// ===== rtl/life_generation_stencil_unit.sv =====
// life_generation_stencil_unit: top level of the streaming life stencil
// instantiates lgs_row_buffer, lgs_window_ctrl and lgs_rule_stage; uses lgs_pkg

// Takes the current generation as a raster stream of one-bit cells, one
// transfer per clock, and returns the next generation in raster order under
// rule B3/S23; first and last rows and columns pass through unchanged. The
// output lags the input by board_width+1 items, so after each frame the host
// sends board_width+1 pad transfers (tuser high) to flush the tail; the
// transfer with tlast high closes the output frame and the position restarts.
// One item is accepted every clock as long as results are taken; the snapshot
// register loads with the transfer that completes a window, and the rule result
// then loads the result register once that register is free. The two previous
// rows sit in one MAX_WIDTH x 2 bit memory read one column ahead, which needs no
// clearing pass after reset. A csr write clamps the value to 3..MAX and restarts
// the frame position; write it only while idle.

module life_generation_stencil_unit #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [lgs_pkg::CSR_WIDTH-1:0] csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] cell_alive, [7:1] zero
   input  logic [0:0]                    req_tuser,   // [0] cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [0] next_alive, [7:1] zero
   output logic                          rsp_tlast
);

   import lgs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic          out_ready;
   logic          s1_valid;
   stage_type     s1_stage;
   logic [CW-1:0] rd_addr;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   logic [1:0]    wr_data;
   logic [1:0]    rd_data;
   logic          next_alive;

   lgs_row_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_row_buffer (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   lgs_window_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser[0]),
      .req_cell  (req_tdata[0]),
      .req_ready (req_tready),
      .out_ready (out_ready),
      .s1_valid  (s1_valid),
      .s1_stage  (s1_stage),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

   lgs_rule_stage u_rule_stage (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_stage   (s1_stage),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .next_alive (next_alive),
      .frame_last (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, next_alive};

endmodule

// ===== dv/tb.sv =====
// tb: self-checking bench for life_generation_stencil_unit, one B3/S23 generation per frame
// predicts cells by a bit-level stencil model or directed rows; needs lgs_pkg and the unit rtl

module tb;
   import lgs_pkg::*;

   localparam int unsigned BOARD_MAX = 128;

   typedef struct packed {
      logic next_alive;
      logic frame_last;
   } cell_result_type;

   typedef struct packed {
      logic cmd;
      logic alive;
      logic typed;
      logic emits;
      logic next_alive;
      logic frame_last;
   } board_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   logic                 csr_index  = 1'b0;
   logic [CSR_WIDTH-1:0] csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [0] cell_alive, [7:1] zero
   logic [0:0]           req_tuser  = '0;   // [0] cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [0] next_alive, [7:1] zero
   logic                 rsp_tlast;

   // generation model state
   bit          line_bits [2*BOARD_MAX];  // low half: row above, high half: two rows above
   bit [8:0]    stencil;
   int unsigned in_col, in_row, out_pos;
   int unsigned board_w = WIDTH_RESET;
   int unsigned board_h = HEIGHT_RESET;

   cell_result_type pending_cells [$];
   board_row_type   board_rows [$];
   bit              idle_on = 1'b1;
   int              mismatches = 0;

   life_generation_stencil_unit #(
      .MAX_WIDTH  (BOARD_MAX),
      .MAX_HEIGHT (BOARD_MAX)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int unsigned clamp_side(input logic [7:0] v, input int unsigned hi);
      if (v < MIN_SIDE) return 32'(MIN_SIDE);
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   task automatic restart_position();
      stencil = '0;
      in_col  = 0;
      in_row  = 0;
      out_pos = 0;
   endtask

   // one accepted item of the current generation; yields the next-generation cell it completes
   task automatic life_step(input logic cmd, input logic alive, output bit emits,
                            output cell_result_type outcome);
      logic        fresh, top, mid, centre;
      int unsigned orow, ocol, live;
      fresh = (cmd == CMD_PAD) ? 1'b0 : alive;
      top   = line_bits[BOARD_MAX + in_col];
      mid   = line_bits[in_col];
      line_bits[BOARD_MAX + in_col] = mid;
      line_bits[in_col] = fresh;
      stencil = {stencil[5:0], fresh, mid, top};
      emits = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= board_w) begin
         in_col = 0;
         in_row++;
      end
      outcome = '0;
      if (emits) begin
         orow   = out_pos / board_w;
         ocol   = out_pos % board_w;
         centre = stencil[4];
         if (orow == 0 || orow >= board_h - 1 || ocol == 0 || ocol >= board_w - 1) begin
            outcome.next_alive = centre;
         end else begin
            live = 0;
            for (int b = 0; b < 9; b++) begin
               if (b != 4) live += stencil[b];
            end
            outcome.next_alive = centre ? (live == KEEP_COUNT || live == BIRTH_COUNT)
                                        : (live == BIRTH_COUNT);
         end
         outcome.frame_last = (out_pos >= board_w * board_h - 1);
         out_pos++;
         if (outcome.frame_last) restart_position();
      end
   endtask

   // valid stays up after a transfer so back-to-back items never toggle it in one step
   // ready only moves at rising edges, so it is sampled at the falling edge before
   task automatic send_item(input logic cmd, input logic alive);
      int   gap;
      logic taken;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, alive};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
   endtask

   task automatic feed(input logic cmd, input logic alive);
      bit              emits;
      cell_result_type outcome;
      send_item(cmd, alive);
      life_step(cmd, alive, emits, outcome);
      if (emits) pending_cells.push_back(outcome);
   endtask

   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_board(input logic [7:0] width_val, input logic [7:0] height_val);
      csr_we    <= 1'b1;
      csr_index <= CFG_BOARD_WIDTH;
      csr_wdata <= width_val;
      @(posedge clock);
      csr_index <= CFG_BOARD_HEIGHT;
      csr_wdata <= height_val;
      @(posedge clock);
      csr_we <= 1'b0;
      board_w = clamp_side(width_val, BOARD_MAX);
      board_h = clamp_side(height_val, BOARD_MAX);
      restart_position();
   endtask

   task automatic add_row(input logic cmd, input logic alive, input logic typed,
                          input logic emits, input logic next_alive, input logic frame_last);
      board_rows.push_back({cmd, alive, typed, emits, next_alive, frame_last});
   endtask

   initial begin : result_sink
      int              stall;
      logic            seen, got_alive, got_last;
      cell_result_type want;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         seen = 1'b0;
         while (!seen) begin
            @(negedge clock);
            seen      = rsp_tvalid;
            got_alive = rsp_tdata[0];
            got_last  = rsp_tlast;
            @(posedge clock);
         end
         if (pending_cells.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual next_alive %0b frame_last %0b",
                     $time, got_alive, got_last);
            mismatches++;
         end else begin
            want = pending_cells.pop_front();
            if (got_alive !== want.next_alive) begin
               $display("%0t: next_alive expected %0b actual %0b",
                        $time, want.next_alive, got_alive);
               mismatches++;
            end
            if (got_last !== want.frame_last) begin
               $display("%0t: frame_last expected %0b actual %0b",
                        $time, want.frame_last, got_last);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      bit              emits;
      cell_result_type outcome;
      int              frames, density, frame_len, pause_at, trunc_len;
      logic            cmd;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x3 board from below-range writes; only the centre cell follows the rule
      set_board(8'd0, 8'd1);

      // all alive: border passes, centre dies of crowding; pads carry a stray alive bit
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 1, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 1, 1, 0, 0);
      add_row(CMD_PAD,  1, 1, 1, 1, 0);
      add_row(CMD_PAD,  1, 1, 1, 1, 0);
      add_row(CMD_PAD,  1, 1, 1, 1, 0);
      add_row(CMD_PAD,  1, 1, 1, 1, 1);
      // dead centre given by a mid-frame pad, three neighbours: birth; cells in the tail
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 0, 1, 0, 0, 0);
      add_row(CMD_CELL, 1, 1, 0, 0, 0);
      add_row(CMD_CELL, 0, 1, 0, 0, 0);
      add_row(CMD_PAD,  1, 1, 1, 1, 0);
      add_row(CMD_CELL, 0, 1, 1, 0, 0);
      add_row(CMD_CELL, 0, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 1, 1, 0, 0);
      add_row(CMD_CELL, 0, 1, 1, 1, 0);
      add_row(CMD_CELL, 1, 0, 0, 0, 0);
      add_row(CMD_CELL, 1, 0, 0, 0, 0);
      add_row(CMD_PAD,  0, 0, 0, 0, 0);
      add_row(CMD_PAD,  0, 0, 0, 0, 0);

      foreach (board_rows[i]) begin
         send_item(board_rows[i].cmd, board_rows[i].alive);
         life_step(board_rows[i].cmd, board_rows[i].alive, emits, outcome);
         if (board_rows[i].typed) begin
            if (board_rows[i].emits)
               pending_cells.push_back({board_rows[i].next_alive, board_rows[i].frame_last});
         end else if (emits) begin
            pending_cells.push_back(outcome);
         end
      end

      for (int ph = 0; ph < 10; ph++) begin
         drain(4);
         case (ph)
            0: begin
               set_board(8'd2, 8'd200);
               frames = 1;
            end
            1: begin
               set_board(8'd255, 8'd3);
               frames = 1;
            end
            default: begin
               set_board(8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)));
               frames = $urandom_range(1, 2);
            end
         endcase
         frame_len = board_w * board_h + board_w + 1;

         for (int f = 0; f < frames; f++) begin
            density  = $urandom_range(20, 60);
            pause_at = $urandom_range(0, frame_len - 1);
            for (int k = 0; k < frame_len; k++) begin
               if (k == pause_at) drain(0);
               if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
               // mostly clean frames: rare pads inside the board, rare cells in the tail
               if (k < board_w * board_h)
                  cmd = ($urandom_range(0, 19) == 0) ? CMD_PAD : CMD_CELL;
               else
                  cmd = ($urandom_range(0, 9) == 0) ? CMD_CELL : CMD_PAD;
               feed(cmd, $urandom_range(0, 99) < density);
            end
         end

         // a cut-off frame of noise; the next csr write restarts the position
         if ($urandom_range(0, 1)) begin
            trunc_len = $urandom_range(1, frame_len - 1);
            for (int k = 0; k < trunc_len; k++) begin
               cmd = $urandom_range(0, 1) ? CMD_PAD : CMD_CELL;
               feed(cmd, 1'($urandom_range(0, 1)));
            end
         end
      end

      drain(8);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
